>>> rtl/xxtea_pkg.sv
`default_nettype none

package xxtea_pkg;

    // Block and word geometry.
    localparam int MAX_WORDS = 64;
    localparam int WORD_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int ROUND_W   = 6;
    localparam int CFG_IDX_W = 3;

    // Key schedule constant.
    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    typedef logic [WORD_W-1:0]       t_word;
    typedef logic [3:0][WORD_W-1:0]  t_key;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 3'd0,
        CFG_KEY_0 = 3'd1,
        CFG_KEY_1 = 3'd2,
        CFG_KEY_2 = 3'd3,
        CFG_KEY_3 = 3'd4
    } t_cfg_index;

    // One input request.
    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              last_word;
    } t_in;

    // One result request.
    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic              result_last;
    } t_out;

    // Number of full rounds, 6 + 52/n, as a small table over n.
    function automatic logic [ROUND_W-1:0] rounds_for(input logic [CNT_W-1:0] n);
        logic [ROUND_W-1:0] rounds;
        begin
            if (n >= CNT_W'(53))      rounds = 6'd6;
            else if (n >= CNT_W'(27)) rounds = 6'd7;
            else if (n >= CNT_W'(18)) rounds = 6'd8;
            else if (n >= CNT_W'(14)) rounds = 6'd9;
            else if (n >= CNT_W'(11)) rounds = 6'd10;
            else if (n >= CNT_W'(9))  rounds = 6'd11;
            else if (n == CNT_W'(8))  rounds = 6'd12;
            else if (n == CNT_W'(7))  rounds = 6'd13;
            else if (n == CNT_W'(6))  rounds = 6'd14;
            else if (n == CNT_W'(5))  rounds = 6'd16;
            else if (n == CNT_W'(4))  rounds = 6'd19;
            else if (n == CNT_W'(3))  rounds = 6'd23;
            else if (n == CNT_W'(2))  rounds = 6'd32;
            else                      rounds = 6'd58;
            return rounds;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/xxtea_block_cipher.sv
`default_nettype none

// Channel   | Signals                                   | Moves
// ----------+-------------------------------------------+---------------------------
// input     | i_in_valid, o_in_ready, i_in_data         | one block word per request
// output    | o_out_valid, i_out_ready, o_out_data      | one result word per request
// config    | i_cfg_wr_en, i_cfg_index, i_cfg_wdata     | mode and four key words
//
// Words load at one per cycle into a 64-entry two-read-port RAM.
// After the last word, the S_SETUP and S_PRIME states follow, then one cycle per
// mixing step through the single mixing unit: (6 + 52/n) rounds of n steps. Results
// then leave at one per cycle, save while stalled, after S_OUT_RD; a one-word
// block skips the mixing. Reset is synchronous and active low; the RAM is not
// cleared. A stalled output holds its word; no input is taken until the block is out.

module xxtea_block_cipher (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [xxtea_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [xxtea_pkg::WORD_W-1:0]     i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire xxtea_pkg::t_in                   i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output xxtea_pkg::t_out                       o_out_data
);

    import xxtea_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP,
        S_PRIME,
        S_RUN,
        S_OUT_RD,
        S_OUT
    } t_state;

    // Configuration registers.
    logic r_mode;
    t_key r_key;

    // Sequencer state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_last_idx, n_last_idx;
    logic [ADDR_W-1:0]  r_p, n_p;
    logic [ADDR_W-1:0]  r_k, n_k;
    logic [ROUND_W-1:0] r_rounds, n_rounds;
    t_word              r_sum, n_sum;
    t_word              r_carry, n_carry;
    logic               r_hit_a, r_hit_b;
    t_word              r_byp;

    // RAM ports.
    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_word             wdata;
    logic              re_a, re_b;
    logic [ADDR_W-1:0] addr_a, addr_b;
    t_word             rd_a_raw, rd_b_raw;
    t_word             rd_a, rd_b;

    // Step control.
    t_word             mix_out;
    logic [ADDR_W-1:0] first_p;
    logic [ADDR_W-1:0] step_p;
    logic              end_round;
    logic [CNT_W-1:0]  count_inc;
    logic              in_accept;

    // Index of the word paired with position p within the current block.
    function automatic logic [ADDR_W-1:0] neighbor(
        input logic [ADDR_W-1:0] p,
        input logic              decrypt,
        input logic [ADDR_W-1:0] last_idx
    );
        logic [ADDR_W-1:0] idx;
        begin
            if (decrypt) begin
                idx = (p == '0) ? last_idx : p - 1'b1;
            end else begin
                idx = (p == last_idx) ? '0 : p + 1'b1;
            end
            return idx;
        end
    endfunction

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_key  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MODE:  r_mode   <= i_cfg_wdata[0];
                CFG_KEY_0: r_key[0] <= i_cfg_wdata;
                CFG_KEY_1: r_key[1] <= i_cfg_wdata;
                CFG_KEY_2: r_key[2] <= i_cfg_wdata;
                CFG_KEY_3: r_key[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    xxtea_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_WORDS)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (we),
        .i_wr_addr  (waddr),
        .i_wr_data  (wdata),
        .i_rd_en_a  (re_a),
        .i_rd_addr_a(addr_a),
        .o_rd_data_a(rd_a_raw),
        .i_rd_en_b  (re_b),
        .i_rd_addr_b(addr_b),
        .o_rd_data_b(rd_b_raw)
    );

    // A read issued in the same cycle as a write to its address takes the new word.
    assign rd_a = r_hit_a ? r_byp : rd_a_raw;
    assign rd_b = r_hit_b ? r_byp : rd_b_raw;

    xxtea_mix u_mix (
        .i_value   (rd_a),
        .i_neighbor(rd_b),
        .i_carry   (r_carry),
        .i_sum     (r_sum),
        .i_key     (r_key),
        .i_pos     (r_p[1:0]),
        .i_decrypt (r_mode),
        .o_value   (mix_out)
    );

    assign first_p   = r_mode ? r_last_idx : '0;
    assign end_round = r_mode ? (r_p == '0) : (r_p == r_last_idx);
    assign step_p    = end_round ? first_p : (r_mode ? r_p - 1'b1 : r_p + 1'b1);
    assign count_inc = r_count + CNT_W'(1);
    assign in_accept = i_in_valid && o_in_ready;

    assign o_in_ready              = (r_state == S_LOAD);
    assign o_out_valid             = (r_state == S_OUT);
    assign o_out_data.result_word  = rd_a;
    assign o_out_data.result_last  = (r_k == r_last_idx);

    // Sequencer: load, set up, one mixing step per cycle, then drain.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_last_idx = r_last_idx;
        n_p        = r_p;
        n_k        = r_k;
        n_rounds   = r_rounds;
        n_sum      = r_sum;
        n_carry    = r_carry;
        we         = 1'b0;
        waddr      = r_p;
        wdata      = mix_out;
        re_a       = 1'b0;
        re_b       = 1'b0;
        addr_a     = r_k;
        addr_b     = r_last_idx;

        unique case (r_state)
            S_LOAD: begin
                if (in_accept) begin
                    we      = 1'b1;
                    waddr   = r_count[ADDR_W-1:0];
                    wdata   = i_in_data.data_word;
                    n_count = count_inc;
                    if (i_in_data.last_word || count_inc == CNT_W'(MAX_WORDS)) begin
                        n_last_idx = r_count[ADDR_W-1:0];
                        n_count    = '0;
                        n_k        = '0;
                        n_state    = (r_count == '0) ? S_OUT_RD : S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                // Fetch the word carried into the first step.
                n_rounds = rounds_for(CNT_W'(r_last_idx) + CNT_W'(1));
                re_b     = 1'b1;
                addr_b   = r_mode ? '0 : r_last_idx;
                n_state  = S_PRIME;
            end
            S_PRIME: begin
                n_carry = rd_b;
                n_sum   = r_mode ? WORD_W'(WORD_W'(r_rounds) * DELTA) : DELTA;
                n_p     = first_p;
                re_a    = 1'b1;
                re_b    = 1'b1;
                addr_a  = first_p;
                addr_b  = neighbor(first_p, r_mode, r_last_idx);
                n_state = S_RUN;
            end
            S_RUN: begin
                we      = 1'b1;
                waddr   = r_p;
                wdata   = mix_out;
                n_carry = mix_out;
                n_p     = step_p;
                re_a    = 1'b1;
                re_b    = 1'b1;
                addr_a  = step_p;
                addr_b  = neighbor(step_p, r_mode, r_last_idx);
                if (end_round) begin
                    n_rounds = r_rounds - 1'b1;
                    n_sum    = r_mode ? r_sum - DELTA : r_sum + DELTA;
                    if (r_rounds == ROUND_W'(1)) begin
                        n_k     = '0;
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_OUT_RD: begin
                re_a    = 1'b1;
                addr_a  = r_k;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_k == r_last_idx) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k    = r_k + 1'b1;
                        re_a   = 1'b1;
                        addr_a = r_k + 1'b1;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_rounds <= '0;
            r_sum    <= '0;
            r_hit_a  <= 1'b0;
            r_hit_b  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rounds <= n_rounds;
            r_sum    <= n_sum;
            if (re_a) begin
                r_hit_a <= we && (waddr == addr_a);
            end
            if (re_b) begin
                r_hit_b <= we && (waddr == addr_b);
            end
        end
        r_last_idx <= n_last_idx;
        r_p        <= n_p;
        r_k        <= n_k;
        r_carry    <= n_carry;
        if (we && (re_a || re_b)) begin
            r_byp <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/xxtea_ram.sv
`default_nettype none

module xxtea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    input  wire logic                     i_rd_en_b,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // One write port, two registered read ports; a read returns the old data
    // when it hits the address written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en_a) begin
            r_rd_a <= r_mem[i_rd_addr_a];
        end
        if (i_rd_en_b) begin
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

>>> rtl/xxtea_mix.sv
`default_nettype none

module xxtea_mix (
    input  wire xxtea_pkg::t_word i_value,
    input  wire xxtea_pkg::t_word i_neighbor,
    input  wire xxtea_pkg::t_word i_carry,
    input  wire xxtea_pkg::t_word i_sum,
    input  wire xxtea_pkg::t_key  i_key,
    input  wire logic [1:0]       i_pos,
    input  wire logic             i_decrypt,
    output xxtea_pkg::t_word      o_value
);

    import xxtea_pkg::*;

    t_word      y;
    t_word      z;
    t_word      mix_a;
    t_word      mix_b;
    t_word      mix;
    logic [1:0] key_sel;

    // Encryption carries z from the previous step and reads y ahead;
    // decryption carries y and reads z behind.
    assign y = i_decrypt ? i_carry : i_neighbor;
    assign z = i_decrypt ? i_neighbor : i_carry;

    assign key_sel = i_pos ^ i_sum[3:2];

    // The XXTEA mixing function.
    assign mix_a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    assign mix_b = (i_sum ^ y) + (i_key[key_sel] ^ z);
    assign mix   = mix_a ^ mix_b;

    assign o_value = i_decrypt ? (i_value - mix) : (i_value + mix);

endmodule

`default_nettype wire
